[hdl/mls_pkg.sv]
package mls_pkg;
   localparam int MaxRadius  = 6;
   localparam int SampleBits = 24;
   localparam int WeightBits = 16;
   localparam int RadiusBits = 3;
   localparam int CsrIdxBits = 4;
   localparam int CsrDataBits = 16;
   localparam int WeightCount = 7;

   localparam logic [CsrIdxBits-1:0] CsrRadius  = 4'd0;
   localparam logic [CsrIdxBits-1:0] CsrWeight0 = 4'd1;
   localparam logic [CsrIdxBits-1:0] CsrWeightLast = 4'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MAC,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load;      // shift in the accepted word
      logic start_pos; // begin one output position
      logic mac_step;  // one tap
      logic div_start; // begin division
      logic div_step;  // one quotient bit
      logic emit;      // result taken, step the centre back
      logic finish;    // end of word, clear on line end
   } cmd_type;

   typedef struct packed {
      logic pending;   // a position is due for output
      logic mac_done;
      logic div_done;
   } stat_type;
endpackage

[hdl/mls_stream_if.sv]
interface mls_stream_if #(
   parameter int DataBits = mls_pkg::SampleBits
) ();
   logic                valid;
   logic                ready;
   logic [DataBits-1:0] data;
   logic                last;

   modport source (output valid, output data, output last, input ready);
   modport sink   (input valid, input data, input last, output ready);
endinterface

[hdl/masked_line_smoother.sv]
// Masked line smoother: normalised, masked 1-D convolution along a line.
// req channel: one word per sample (data = sample, last = line end).
// rsp channel: one word per line position (data = smoothed, last = line last).
// csr port: write index 0 = radius, 1..7 = weights for distance 0..6.
// Each accepted word yields 0 to MAX_RADIUS+1 result words; output lags
// input by the radius and the line end word flushes the line.
// A word that releases nothing passes only through the accept and check states.
// Each result adds a check, one MAC step per tap (at most 2*radius+1 taps),
// a divider set-up, the division (one quotient bit a cycle over the full
// numerator width, then the sign fix-up) and the output handshake.
// One word is taken at a time; req_ready is high only when idle.
// When the receiver stalls, the result holds on rsp until taken and
// req_ready stays low.
// Reset: synchronous, clears window, counts and loads default registers.
module masked_line_smoother #(
   parameter int MAX_RADIUS  = mls_pkg::MaxRadius,
   parameter int SAMPLE_BITS = mls_pkg::SampleBits
) (
   input  logic                            clock,
   input  logic                            reset,
   mls_stream_if.sink                      req,
   mls_stream_if.source                    rsp,
   input  logic                            csr_write,
   input  logic [mls_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [mls_pkg::CsrDataBits-1:0] csr_data
);
   mls_pkg::cmd_type  cmd;
   mls_pkg::stat_type stat;

   mls_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .stat, .cmd
   );

   mls_datapath #(.MAX_RADIUS(MAX_RADIUS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock, .reset,
      .csr_write, .csr_index, .csr_data,
      .in_sample(req.data), .in_end(req.last),
      .cmd, .stat,
      .out_smoothed(rsp.data), .out_last(rsp.last)
   );
endmodule

[hdl/mls_ctrl.sv]
module mls_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   input  mls_pkg::stat_type       stat,
   output mls_pkg::cmd_type        cmd
);
   mls_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mls_pkg::ST_IDLE:  if (in_valid) state_in = mls_pkg::ST_CHECK;
         mls_pkg::ST_CHECK: state_in = stat.pending ? mls_pkg::ST_MAC : mls_pkg::ST_IDLE;
         mls_pkg::ST_MAC:   if (stat.mac_done) state_in = mls_pkg::ST_PREP;
         mls_pkg::ST_PREP:  state_in = mls_pkg::ST_DIV;
         mls_pkg::ST_DIV:   if (stat.div_done) state_in = mls_pkg::ST_OUT;
         mls_pkg::ST_OUT:   if (out_ready) state_in = mls_pkg::ST_CHECK;
         default:           state_in = mls_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         mls_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         mls_pkg::ST_CHECK: begin
            cmd.start_pos = stat.pending;
            cmd.finish = !stat.pending;
         end
         mls_pkg::ST_MAC: cmd.mac_step = 1'b1;
         mls_pkg::ST_PREP: cmd.div_start = 1'b1;
         mls_pkg::ST_DIV: cmd.div_step = 1'b1;
         mls_pkg::ST_OUT: begin
            out_valid = 1'b1;
            cmd.emit = out_ready;
         end
         default: ;
      endcase
   end

   a_out_only_in_out: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> state_ff == mls_pkg::ST_OUT) else $error("out_valid outside output");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (in_ready && out_valid) == 1'b0) else $error("accept while result pending");
   a_mac_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mls_pkg::ST_MAC && stat.mac_done) |=> state_ff == mls_pkg::ST_PREP)
      else $error("mac did not hand over");
endmodule

[hdl/mls_datapath.sv]
module mls_datapath #(
   parameter int MAX_RADIUS  = mls_pkg::MaxRadius,
   parameter int SAMPLE_BITS = mls_pkg::SampleBits
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [mls_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [mls_pkg::CsrDataBits-1:0] csr_data,
   input  logic [SAMPLE_BITS-1:0]        in_sample,
   input  logic                          in_end,
   input  mls_pkg::cmd_type              cmd,
   output mls_pkg::stat_type             stat,
   output logic [SAMPLE_BITS-1:0]        out_smoothed,
   output logic                          out_last
);
   localparam int Depth   = 2 * MAX_RADIUS + 1;
   localparam int CntBits = $clog2(Depth + 1);
   localparam int WB      = mls_pkg::WeightBits;
   localparam int WIdxBits = $clog2(MAX_RADIUS + 1);
   localparam int DenBits = WB + CntBits;
   localparam int NumBits = SAMPLE_BITS + WB + CntBits;
   localparam int QBits   = NumBits;

   logic [SAMPLE_BITS-1:0] win_ff [Depth];
   logic [CntBits-1:0] fill_ff, centre_ff;
   logic [mls_pkg::RadiusBits-1:0] radius_ff;
   logic [WB-1:0] weight_ff [MAX_RADIUS+1];
   logic end_ff;

   logic [CntBits-1:0] eff_r, lim, age_ff, k_ff, hi_ff;
   logic signed [NumBits-1:0] num_ff;
   logic [DenBits-1:0] den_ff;
   logic [QBits-1:0] quo_ff, rem_ff;
   logic neg_ff;
   logic [$clog2(QBits+1)-1:0] bit_ff;
   logic [SAMPLE_BITS-1:0] res_ff;
   logic last_ff;

   always_comb begin
      eff_r = CntBits'(radius_ff);
      if (radius_ff == '0) eff_r = CntBits'(1);
      if (int'(radius_ff) > MAX_RADIUS) eff_r = CntBits'(MAX_RADIUS);
      lim = end_ff ? '0 : eff_r;
   end
   assign stat.pending = centre_ff > lim;

   // tap distance and weight
   logic [CntBits-1:0] tap_dist;
   logic [WB-1:0] tap_w;
   logic [SAMPLE_BITS-1:0] tap_s;
   assign tap_dist = (k_ff > age_ff) ? k_ff - age_ff : age_ff - k_ff;
   assign tap_s = win_ff[k_ff[$clog2(Depth)-1:0]];
   always_comb begin
      tap_w = '0;
      for (int i = 0; i <= MAX_RADIUS; i++)
         if (tap_dist == CntBits'(i)) tap_w = weight_ff[i];
   end
   assign stat.mac_done = (k_ff >= hi_ff);

   logic signed [SAMPLE_BITS+WB:0] prod;
   assign prod = $signed(tap_s) * $signed({1'b0, tap_w});

   logic [QBits-1:0] num_abs;
   assign num_abs = num_ff[NumBits-1] ? QBits'(-num_ff) : QBits'(num_ff);

   logic [QBits:0] trial;
   assign trial = {rem_ff, quo_ff[QBits-1]} - {{(QBits-DenBits+1){1'b0}}, den_ff};
   assign stat.div_done = (bit_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= mls_pkg::RadiusBits'(1);
         for (int i = 0; i <= MAX_RADIUS; i++) weight_ff[i] <= '0;
         weight_ff[0] <= '1;
         fill_ff <= '0;
         centre_ff <= '0;
         end_ff <= 1'b0;
         for (int i = 0; i < Depth; i++) win_ff[i] <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == mls_pkg::CsrRadius)
               radius_ff <= csr_data[mls_pkg::RadiusBits-1:0];
            else if (csr_index >= mls_pkg::CsrWeight0 && csr_index <= mls_pkg::CsrWeightLast
                     && int'(csr_index) - 1 <= MAX_RADIUS)
               weight_ff[WIdxBits'(csr_index - mls_pkg::CsrWeight0)] <= csr_data[WB-1:0];
         end
         if (cmd.load) begin
            for (int i = Depth - 1; i > 0; i--) win_ff[i] <= win_ff[i-1];
            win_ff[0] <= in_sample;
            end_ff <= in_end;
            if (int'(fill_ff) < Depth) fill_ff <= fill_ff + 1'b1;
            if (int'(centre_ff) < Depth) centre_ff <= centre_ff + 1'b1;
         end
         if (cmd.emit) centre_ff <= centre_ff - 1'b1;
         if (cmd.finish && end_ff) begin
            fill_ff <= '0;
            centre_ff <= '0;
            end_ff <= 1'b0;
            for (int i = 0; i < Depth; i++) win_ff[i] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_pos) begin
         age_ff <= centre_ff - 1'b1;
         k_ff   <= (centre_ff - 1'b1 > eff_r) ? centre_ff - 1'b1 - eff_r : '0;
         hi_ff  <= (centre_ff - 1'b1 + eff_r > fill_ff - 1'b1) ? fill_ff - 1'b1
                   : centre_ff - 1'b1 + eff_r;
         num_ff <= '0;
         den_ff <= '0;
         last_ff <= end_ff && centre_ff == CntBits'(1);
      end
      if (cmd.mac_step) begin
         if (tap_s != '0 && int'(tap_dist) <= MAX_RADIUS) begin
            num_ff <= num_ff + NumBits'(prod);
            den_ff <= den_ff + DenBits'(tap_w);
         end
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.div_start) begin
         quo_ff <= num_abs;
         rem_ff <= '0;
         neg_ff <= num_ff[NumBits-1];
         bit_ff <= ($clog2(QBits+1))'(QBits);
      end
      if (cmd.div_step && bit_ff != '0) begin
         // restoring division, one quotient bit a cycle
         if (!trial[QBits]) begin
            rem_ff <= trial[QBits-1:0];
            quo_ff <= {quo_ff[QBits-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[QBits-2:0], quo_ff[QBits-1]};
            quo_ff <= {quo_ff[QBits-2:0], 1'b0};
         end
         bit_ff <= bit_ff - 1'b1;
      end
      if (cmd.div_step && bit_ff == '0) begin
         if (den_ff == '0) res_ff <= '0;
         else res_ff <= neg_ff ? SAMPLE_BITS'(-quo_ff) : SAMPLE_BITS'(quo_ff);
      end
   end
   assign out_smoothed = res_ff;
   assign out_last = last_ff;

   a_centre_bound: assert property (@(posedge clock) disable iff (reset)
      int'(centre_ff) <= Depth) else $error("centre out of range");
   a_fill_ge_centre: assert property (@(posedge clock) disable iff (reset)
      centre_ff <= fill_ff) else $error("centre beyond fill");
   a_emit_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !cmd.load |=> centre_ff == $past(centre_ff) - 1'b1)
      else $error("centre not advanced");
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   localparam int SampleBits  = mls_pkg::SampleBits;
   localparam int MaxRadius   = mls_pkg::MaxRadius;
   localparam int IdxBits     = mls_pkg::CsrIdxBits;
   localparam int DataBits    = mls_pkg::CsrDataBits;
   localparam int RadBits     = mls_pkg::RadiusBits;
   localparam int WBits       = mls_pkg::WeightBits;
   localparam int WCount      = mls_pkg::WeightCount;
   localparam int WinDepth  = 2 * MaxRadius + 1;
   localparam int IdleLimit = 20000;

   // Fixed expected values, typed in only where they can be read at a glance.
   typedef struct {
      logic signed [SampleBits-1:0] sample;
      logic                         line_end;
      logic                         has_fixed;
      logic signed [SampleBits-1:0] fixed_value;
   } stim_row_type;

   typedef struct {
      logic signed [SampleBits-1:0] smoothed;
      logic                         line_last;
   } smoothed_word_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [IdxBits-1:0]  csr_index;
   logic [DataBits-1:0] csr_data;

   mls_stream_if #(.DataBits(SampleBits)) req_if ();
   mls_stream_if #(.DataBits(SampleBits)) rsp_if ();

   masked_line_smoother DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Predictor state: our own copy of the window and the registers.
   logic signed [SampleBits-1:0] line_window [WinDepth];
   int unsigned                  window_fill;
   int unsigned                  pending_count;
   logic [RadBits-1:0]           radius_reg;
   logic [WBits-1:0]             weight_reg [WCount];

   smoothed_word_type smoothed_queue [$];
   int  mismatch_count;
   int  idle_cycles;
   bit  long_hold;

   // Optional fixed value for the next expectation(s) from a directed row.
   bit                           fixed_pending;
   logic signed [SampleBits-1:0] fixed_value;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic int unsigned active_radius();
      int unsigned r;
      r = radius_reg;
      if (r < 1) r = 1;
      if (r > MaxRadius) r = MaxRadius;
      return r;
   endfunction

   // Normalised weighted average at window age a, masked samples skipped.
   function automatic logic signed [SampleBits-1:0] weighted_average(int unsigned a,
                                                                   int unsigned r);
      longint num;
      longint den;
      longint s;
      int unsigned lo;
      int unsigned hi;
      int unsigned d;
      num = 0;
      den = 0;
      if (window_fill == 0) return '0;
      lo = (a > r) ? a - r : 0;
      hi = a + r;
      if (hi > window_fill - 1) hi = window_fill - 1;
      if (hi > WinDepth - 1) hi = WinDepth - 1;
      for (int unsigned k = lo; k <= hi; k++) begin
         s = line_window[k];
         d = (k > a) ? k - a : a - k;
         if (s != 0 && d <= MaxRadius) begin
            num += s * longint'(weight_reg[d]);
            den += longint'(weight_reg[d]);
         end
      end
      if (den == 0) return '0;
      return SampleBits'(num / den);
   endfunction

   // Shift one accepted word in and queue every position it releases.
   task automatic predict_smoothed(input logic signed [SampleBits-1:0] sample,
                                   input logic line_end);
      int unsigned r;
      int unsigned hold;
      int unsigned produced;
      smoothed_word_type w;
      r = active_radius();
      hold = line_end ? 0 : r;
      produced = 0;
      for (int i = WinDepth - 1; i > 0; i--) line_window[i] = line_window[i-1];
      line_window[0] = sample;
      if (window_fill < WinDepth) window_fill++;
      if (pending_count < WinDepth) pending_count++;
      while (pending_count > hold && produced < MaxRadius + 1) begin
         w.smoothed  = weighted_average(pending_count - 1, r);
         w.line_last = line_end && (pending_count == 1);
         if (fixed_pending && w.smoothed != fixed_value)
            report_mismatch("directed table", w.smoothed, fixed_value);
         smoothed_queue.push_back(w);
         produced++;
         pending_count--;
      end
      fixed_pending = 0;
      if (line_end) begin
         foreach (line_window[i]) line_window[i] = '0;
         window_fill = 0;
         pending_count = 0;
      end
   endtask

   // Compare each word taken from rsp with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (smoothed_queue.size() == 0) begin
            report_mismatch("unexpected word", $signed(rsp_if.data), 0);
         end else begin
            if (rsp_if.data != smoothed_queue[0].smoothed)
               report_mismatch("smoothed", $signed(rsp_if.data),
                               smoothed_queue[0].smoothed);
            if (rsp_if.last != smoothed_queue[0].line_last)
               report_mismatch("line_last", rsp_if.last, smoothed_queue[0].line_last);
            void'(smoothed_queue.pop_front());
         end
      end
   end

   // Receiver: random stall, mostly short; a long hold-off on request.
   initial begin
      int gap;
      int quiet;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            for (int i = 0; i < 3000; i++) @(posedge clock);
            long_hold = 0;
         end
         quiet = $urandom_range(0, 3);
         gap = (quiet == 0) ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                               : $urandom_range(0, 3));
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Watchdog: cycles without any accepted word.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // One write, then the enable is held low before returning, so it drops between writes.
   task automatic write_register(input logic [IdxBits-1:0] idx,
                                 input logic [DataBits-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (idx == mls_pkg::CsrRadius) radius_reg = value[RadBits-1:0];
      else if (idx >= mls_pkg::CsrWeight0 && idx <= mls_pkg::CsrWeightLast)
         weight_reg[idx - mls_pkg::CsrWeight0] = value[WBits-1:0];
   endtask

   // Offer one word with a random gap before it; hold until taken.
   task automatic send_word(input logic signed [SampleBits-1:0] sample,
                            input logic line_end, input bit gaps);
      int gap;
      gap = 0;
      if (gaps && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= sample;
      req_if.last  <= line_end;
      // ready only moves at the rising edge, so look at it mid-cycle
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
      predict_smoothed(sample, line_end);
   endtask

   // Wait for every expected word, then allow the block to settle.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (smoothed_queue.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic signed [SampleBits-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return '0;                         // masked out
      if (pick == 3) return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      if (pick < 6) return SampleBits'($signed($urandom_range(0, 400)) - 200);
      return SampleBits'($urandom);
   endfunction

   stim_row_type directed_rows [$];

   initial begin
      stim_row_type row;
      int line_len;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      req_if.last = 1'b0;
      mismatch_count = 0;
      long_hold = 0;
      fixed_pending = 0;
      foreach (line_window[i]) line_window[i] = '0;
      window_fill = 0;
      pending_count = 0;
      radius_reg = 1;
      foreach (weight_reg[i]) weight_reg[i] = '0;
      weight_reg[0] = 16'hffff;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings: only the centre weight counts, so the
      // output equals the sample; a lone-sample line gives itself back.
      directed_rows = '{
         '{24'sh7fffff, 1'b1, 1'b1, 24'sh7fffff},
         '{24'sh800000, 1'b1, 1'b1, 24'sh800000},
         '{24'sh000000, 1'b1, 1'b1, 24'sh000000},
         '{24'sh000005, 1'b0, 1'b0, 24'sh0},
         '{24'sh000000, 1'b0, 1'b0, 24'sh0},
         '{24'shfffff0, 1'b0, 1'b0, 24'sh0},
         '{24'sh7fffff, 1'b1, 1'b0, 24'sh0}
      };
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         fixed_pending = row.has_fixed;
         fixed_value = row.fixed_value;
         send_word(row.sample, row.line_end, 0);
      end
      drain();

      // Wide radius, extreme weights; radius out of range (0 and 7).
      write_register(mls_pkg::CsrRadius, 16'd6);
      for (int d = 0; d < WCount; d++)
         write_register(IdxBits'(int'(mls_pkg::CsrWeight0) + d),
                        (d % 2) ? 16'hffff : 16'h0000);
      write_register(4'd9, 16'h1234);   // index beyond the list is dropped
      for (int i = 0; i < 14; i++)
         send_word((i % 3 == 0) ? 24'sh0 : SampleBits'(i * 1000 - 7000), i == 13, 0);
      drain();
      write_register(mls_pkg::CsrRadius, 16'd0);
      for (int i = 0; i < 4; i++) send_word(SampleBits'(i + 1), i == 3, 0);
      drain();
      write_register(mls_pkg::CsrRadius, 16'd7);
      for (int i = 0; i < 9; i++) send_word(SampleBits'(100 - i * 30), i == 8, 0);
      drain();

      // Random phases: new registers each phase, well-formed lines of random length.
      for (int phase = 0; phase < 8; phase++) begin
         write_register(mls_pkg::CsrRadius, DataBits'($urandom_range(0, 7)));
         for (int d = 0; d < WCount; d++)
            write_register(IdxBits'(int'(mls_pkg::CsrWeight0) + d), (phase == 7) ? 16'hffff :
                           ($urandom_range(0, 5) == 0 ? 16'h0
                                                      : DataBits'($urandom_range(0, 65535))));
         if (phase == 2) long_hold = 1;
         for (int n = 0; n < 48; ) begin
            line_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 20);
            for (int i = 0; i < line_len; i++) begin
               send_word(random_sample(), i == line_len - 1, phase != 2);
               n++;
            end
         end
         drain();
      end

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
hdl/mls_pkg.sv
hdl/mls_stream_if.sv
hdl/mls_ctrl.sv
hdl/mls_datapath.sv
hdl/masked_line_smoother.sv
test/tb_top.sv
